// ===== rtl/iyt_pkg.sv =====
// ----------------------------------------------------------------------------
// iyt_pkg
// Shared types, codes and byte classes of the indent YAML tokenizer.
// ----------------------------------------------------------------------------
package iyt_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int COLUMN_BITS_DEF = 12;
  localparam int OFFSET_BITS_DEF = 24;

  localparam int OUT_W       = 24;
  localparam int MAX_RESULTS = 20;
  localparam int RES_W       = 5;

  typedef enum logic [3:0] {
    M_LINE_START  = 4'd0,
    M_LEAD        = 4'd1,
    M_LINE        = 4'd2,
    M_DASH_PEND   = 4'd3,
    M_AFTER_DASH  = 4'd4,
    M_AFTER_COLON = 4'd5,
    M_BARE_LINE   = 4'd6,
    M_QUOTE_LINE  = 4'd7,
    M_COMMENT     = 4'd8,
    M_LIST        = 4'd9,
    M_BARE_LIST   = 4'd10,
    M_QUOTE_LIST  = 4'd11,
    M_AFTER_CLOSE = 4'd12,
    M_DONE        = 4'd13
  } mode_t;

  typedef enum logic [2:0] {
    P_IDLE   = 3'd0,
    P_EVAL   = 3'd1,
    P_ALIGN  = 3'd2,
    P_POPALL = 3'd3,
    P_FLUSH  = 3'd4,
    P_FLUSH2 = 3'd5,
    P_FINISH = 3'd6
  } phase_t;

  localparam logic [3:0] K_STRING = 4'd0;
  localparam logic [3:0] K_INDENT = 4'd1;
  localparam logic [3:0] K_DEDENT = 4'd2;
  localparam logic [3:0] K_END    = 4'd3;
  localparam logic [3:0] K_DASH   = 4'd4;
  localparam logic [3:0] K_COLON  = 4'd5;
  localparam logic [3:0] K_OPEN   = 4'd6;
  localparam logic [3:0] K_CLOSE  = 4'd7;
  localparam logic [3:0] K_COMMA  = 4'd8;
  localparam logic [3:0] K_ERROR  = 4'd9;

  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_INDENT     = 3'd1;
  localparam logic [2:0] E_UNCLOSED   = 3'd2;
  localparam logic [2:0] E_NO_NEWLINE = 3'd3;
  localparam logic [2:0] E_STRING     = 3'd4;
  localparam logic [2:0] E_BAD_CHAR   = 3'd5;
  localparam logic [2:0] E_STACK_FULL = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef struct packed {
    phase_t op;
    logic   run;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic err_stop;
    logic eot;
    logic busy;
    logic again;
    logic go_align;
    logic go_popall;
    logic go_flush2;
    logic flush_cont;
    logic pass_last;
  } status_t;

  function automatic logic is_bare(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
           c == 8'h5F || c == CH_DASH || c == 8'h2F || c == CH_DOT;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

endpackage

// ===== rtl/iyt_ctrl.sv =====
// ----------------------------------------------------------------------------
// iyt_ctrl
// Phase sequencer: steps each byte through passes, stack walks, end of text
// handling and the final release of its last token.
// ----------------------------------------------------------------------------
module iyt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  iyt_pkg::status_t st,
  output iyt_pkg::cmd_t    cmd
);

  iyt_pkg::phase_t phase, phase_next, post;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= iyt_pkg::P_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    post       = st.eot ? iyt_pkg::P_FLUSH : iyt_pkg::P_FINISH;
    phase_next = phase;
    cmd.op     = phase;
    cmd.accept = (phase == iyt_pkg::P_IDLE) && s_tvalid;
    cmd.run    = (phase != iyt_pkg::P_IDLE) && st.emit_ok;
    s_tready   = (phase == iyt_pkg::P_IDLE);
    case (phase)
      iyt_pkg::P_IDLE: begin
        if (s_tvalid) begin
          phase_next = st.err_stop ? iyt_pkg::P_FINISH : iyt_pkg::P_EVAL;
        end
      end
      iyt_pkg::P_EVAL: begin
        if (st.emit_ok) begin
          if (st.go_align) phase_next = iyt_pkg::P_ALIGN;
          else if (st.go_popall) phase_next = iyt_pkg::P_POPALL;
          else if (st.again && !st.pass_last) phase_next = iyt_pkg::P_EVAL;
          else phase_next = post;
        end
      end
      iyt_pkg::P_ALIGN: begin
        if (st.emit_ok && !st.busy) begin
          if (st.flush_cont) phase_next = iyt_pkg::P_FINISH;
          else if (st.again && !st.pass_last) phase_next = iyt_pkg::P_EVAL;
          else phase_next = post;
        end
      end
      iyt_pkg::P_POPALL: begin
        if (st.emit_ok && !st.busy) phase_next = post;
      end
      iyt_pkg::P_FLUSH: begin
        if (st.emit_ok) begin
          if (st.go_align) phase_next = iyt_pkg::P_ALIGN;
          else if (st.go_flush2) phase_next = iyt_pkg::P_FLUSH2;
          else phase_next = iyt_pkg::P_FINISH;
        end
      end
      iyt_pkg::P_FLUSH2: begin
        if (st.emit_ok) phase_next = iyt_pkg::P_FINISH;
      end
      iyt_pkg::P_FINISH: begin
        if (st.emit_ok) phase_next = iyt_pkg::P_IDLE;
      end
      default: begin
        phase_next = iyt_pkg::P_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/iyt_datapath.sv =====
// ----------------------------------------------------------------------------
// iyt_datapath
// Scanner state, indent column stack, token holding stage and output register.
// ----------------------------------------------------------------------------
module iyt_datapath #(
  parameter int STACK_DEPTH = iyt_pkg::STACK_DEPTH_DEF,
  parameter int COLUMN_BITS = iyt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = iyt_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  iyt_pkg::cmd_t    cmd,
  output iyt_pkg::status_t st,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,
  output logic [3:0]       m_tuser,
  output logic             m_tlast
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic [COLUMN_BITS-1:0] stack [STACK_DEPTH];
  logic [CNT_W-1:0]       cnt, cnt_next, cnt_m1;
  logic [COLUMN_BITS-1:0] top, column, column_next;
  logic [OFFSET_BITS-1:0] offset, offset_next, tok_begin, tok_next;
  logic [OFFSET_BITS-1:0] list_begin, list_next;
  iyt_pkg::mode_t         mode, mode_next, cont_mode, cont_mode_next;
  logic [2:0]             marker, marker_next, pass, pass_next;
  logic                   err_stop, err_next, nl_taken, nl_next;
  logic [7:0]             cbyte;
  logic                   eot;
  logic [COLUMN_BITS-1:0] align_pos, align_pos_next;
  logic                   cont_flush, cont_flush_next, align_first, first_next;
  logic                   push_v, full;
  logic [1:0]             k;
  logic                   dots;
  logic [7:0]             want, qwant;

  logic                   e_v, e_take;
  logic [3:0]             e_kind;
  logic [OFFSET_BITS-1:0] e_off, e_len;
  logic [2:0]             e_code;

  logic [iyt_pkg::RES_W-1:0] res_cnt;
  logic                      held_v;
  logic [3:0]                h_kind, o_kind;
  logic [OFFSET_BITS-1:0]    h_off, h_len, o_off, o_len;
  logic [2:0]                h_code, o_code;
  logic                      o_last;
  logic                      finish_run;

  assign cnt_m1 = cnt - CNT_W'(1);
  assign top    = stack[cnt_m1[IDX_W-1:0]];
  assign full   = cnt >= CNT_W'(STACK_DEPTH);
  assign k      = marker[1:0];
  assign dots   = marker[2];
  assign want   = dots ? iyt_pkg::CH_DOT : iyt_pkg::CH_DASH;
  assign qwant  = (marker != 3'd0) ? iyt_pkg::CH_DQ : iyt_pkg::CH_SQ;

  assign e_take     = cmd.run && e_v && (res_cnt < iyt_pkg::RES_W'(iyt_pkg::MAX_RESULTS));
  assign finish_run = cmd.run && (cmd.op == iyt_pkg::P_FINISH);

  assign st.emit_ok   = !held_v || !m_tvalid || m_tready;
  assign st.err_stop  = err_stop;
  assign st.eot       = eot;
  assign st.flush_cont = cont_flush;
  assign st.pass_last = (pass == 3'd7);

  always_comb begin
    mode_next       = mode;
    marker_next     = marker;
    tok_next        = tok_begin;
    list_next       = list_begin;
    err_next        = err_stop;
    nl_next         = nl_taken;
    cnt_next        = cnt;
    push_v          = 1'b0;
    align_pos_next  = align_pos;
    cont_mode_next  = cont_mode;
    cont_flush_next = cont_flush;
    first_next      = align_first;
    pass_next       = pass;
    offset_next     = offset;
    column_next     = column;
    e_v             = 1'b0;
    e_kind          = iyt_pkg::K_STRING;
    e_off           = tok_begin;
    e_len           = '0;
    e_code          = iyt_pkg::E_NONE;
    st.busy         = 1'b0;
    st.again        = 1'b0;
    st.go_align     = 1'b0;
    st.go_popall    = 1'b0;
    st.go_flush2    = 1'b0;
    if (cmd.accept) begin
      pass_next = 3'd0;
      nl_next   = 1'b0;
    end
    if (cmd.run) begin
      case (cmd.op)
        iyt_pkg::P_EVAL: begin
          case (mode)
            iyt_pkg::M_LINE_START: begin
              if (k == 2'd0 && (cbyte == iyt_pkg::CH_DASH || cbyte == iyt_pkg::CH_DOT)) begin
                marker_next = (cbyte == iyt_pkg::CH_DOT) ? 3'd5 : 3'd1;
              end else if (k != 2'd0 && cbyte == want) begin
                if (k >= 2'd2) st.go_popall = 1'b1;
                else marker_next = marker + 3'd1;
              end else if (k == 2'd0) begin
                mode_next = iyt_pkg::M_LEAD;
                st.again  = 1'b1;
              end else begin
                marker_next     = 3'd0;
                st.go_align     = 1'b1;
                align_pos_next  = '0;
                cont_flush_next = 1'b0;
                first_next      = 1'b1;
                cont_mode_next  = (!dots && k == 2'd1) ? iyt_pkg::M_DASH_PEND
                                                       : iyt_pkg::M_BARE_LINE;
              end
            end
            iyt_pkg::M_LEAD: begin
              if (iyt_pkg::is_blank(cbyte)) begin
                mode_next = mode;
              end else if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end else if (cbyte == iyt_pkg::CH_HASH) begin
                mode_next = iyt_pkg::M_COMMENT;
              end else begin
                st.go_align     = 1'b1;
                align_pos_next  = column;
                cont_flush_next = 1'b0;
                first_next      = 1'b1;
                cont_mode_next  = iyt_pkg::M_LINE;
              end
            end
            iyt_pkg::M_LINE: begin
              if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end else if (cbyte == iyt_pkg::CH_DASH) begin
                tok_next  = offset;
                mode_next = iyt_pkg::M_DASH_PEND;
              end else if (cbyte == iyt_pkg::CH_LBRK) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_OPEN; e_off = offset; e_len = OFFSET_BITS'(1);
                list_next = offset;
                mode_next = iyt_pkg::M_LIST;
              end else if (cbyte == iyt_pkg::CH_SQ || cbyte == iyt_pkg::CH_DQ) begin
                tok_next    = offset;
                marker_next = {2'b00, cbyte == iyt_pkg::CH_DQ};
                mode_next   = iyt_pkg::M_QUOTE_LINE;
              end else if (cbyte == iyt_pkg::CH_HASH) begin
                mode_next = iyt_pkg::M_COMMENT;
              end else if (cbyte == iyt_pkg::CH_COLON) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_COLON; e_off = offset; e_len = OFFSET_BITS'(1);
                mode_next = iyt_pkg::M_AFTER_COLON;
              end else if (iyt_pkg::is_bare(cbyte)) begin
                tok_next  = offset;
                mode_next = iyt_pkg::M_BARE_LINE;
              end else begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = offset;
                e_code = iyt_pkg::E_BAD_CHAR; err_next = 1'b1;
              end
            end
            iyt_pkg::M_DASH_PEND: begin
              if (cbyte == iyt_pkg::CH_SP) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_DASH; e_off = tok_begin; e_len = OFFSET_BITS'(1);
                mode_next = iyt_pkg::M_AFTER_DASH;
              end else begin
                mode_next = iyt_pkg::M_BARE_LINE;
                st.again  = 1'b1;
              end
            end
            iyt_pkg::M_AFTER_DASH: begin
              if (iyt_pkg::is_blank(cbyte)) begin
                mode_next = mode;
              end else if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end else if (full) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = offset;
                e_code = iyt_pkg::E_STACK_FULL; err_next = 1'b1;
              end else begin
                push_v = 1'b1;
                cnt_next = cnt + CNT_W'(1);
                e_v = 1'b1; e_kind = iyt_pkg::K_INDENT; e_off = offset;
                mode_next = iyt_pkg::M_LINE;
                st.again  = 1'b1;
              end
            end
            iyt_pkg::M_AFTER_COLON: begin
              if (iyt_pkg::is_blank(cbyte)) begin
                mode_next = mode;
              end else if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end else begin
                mode_next = iyt_pkg::M_LINE;
                st.again  = 1'b1;
              end
            end
            iyt_pkg::M_BARE_LINE, iyt_pkg::M_BARE_LIST: begin
              if (!iyt_pkg::is_bare(cbyte)) begin
                e_v = 1'b1; e_off = tok_begin; e_len = offset - tok_begin;
                mode_next = (mode == iyt_pkg::M_BARE_LINE) ? iyt_pkg::M_LINE : iyt_pkg::M_LIST;
                st.again  = 1'b1;
              end
            end
            iyt_pkg::M_QUOTE_LINE, iyt_pkg::M_QUOTE_LIST: begin
              if (cbyte == qwant) begin
                e_v = 1'b1; e_off = tok_begin + OFFSET_BITS'(1);
                e_len = offset - tok_begin - OFFSET_BITS'(1);
                mode_next = (mode == iyt_pkg::M_QUOTE_LINE) ? iyt_pkg::M_LINE : iyt_pkg::M_LIST;
                marker_next = 3'd0;
              end
            end
            iyt_pkg::M_COMMENT: begin
              if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end
            end
            iyt_pkg::M_LIST: begin
              if (iyt_pkg::is_blank(cbyte) || cbyte == iyt_pkg::CH_NL) begin
                mode_next = mode;
              end else if (cbyte == iyt_pkg::CH_RBRK) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_CLOSE; e_off = offset; e_len = OFFSET_BITS'(1);
                tok_next  = offset;
                mode_next = iyt_pkg::M_AFTER_CLOSE;
              end else if (cbyte == iyt_pkg::CH_SQ || cbyte == iyt_pkg::CH_DQ) begin
                tok_next    = offset;
                marker_next = {2'b00, cbyte == iyt_pkg::CH_DQ};
                mode_next   = iyt_pkg::M_QUOTE_LIST;
              end else if (cbyte == iyt_pkg::CH_COMMA) begin
                e_v = 1'b1; e_kind = iyt_pkg::K_COMMA; e_off = offset; e_len = OFFSET_BITS'(1);
              end else if (iyt_pkg::is_bare(cbyte)) begin
                tok_next  = offset;
                mode_next = iyt_pkg::M_BARE_LIST;
              end else begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = offset;
                e_code = iyt_pkg::E_BAD_CHAR; err_next = 1'b1;
              end
            end
            iyt_pkg::M_AFTER_CLOSE: begin
              if (iyt_pkg::is_blank(cbyte)) begin
                mode_next = mode;
              end else if (cbyte == iyt_pkg::CH_NL) begin
                mode_next = iyt_pkg::M_LINE_START;
                marker_next = 3'd0;
                tok_next = offset + OFFSET_BITS'(1);
                nl_next = 1'b1;
              end else begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = tok_begin;
                e_code = iyt_pkg::E_NO_NEWLINE; err_next = 1'b1;
              end
            end
            default: begin
              mode_next = mode;
            end
          endcase
          if (err_next) st.again = 1'b0;
          if (!st.go_align && !st.go_popall) pass_next = pass + 3'd1;
        end
        iyt_pkg::P_ALIGN: begin
          first_next = 1'b0;
          if (align_first && top < align_pos) begin
            if (full) begin
              e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = tok_begin;
              e_code = iyt_pkg::E_STACK_FULL; err_next = 1'b1;
            end else begin
              push_v = 1'b1;
              cnt_next = cnt + CNT_W'(1);
              e_v = 1'b1; e_kind = iyt_pkg::K_INDENT; e_off = tok_begin;
              mode_next = cont_mode;
              st.again  = !cont_flush;
            end
          end else if (cnt > CNT_W'(1) && top > align_pos) begin
            cnt_next = cnt_m1;
            e_v = 1'b1; e_kind = iyt_pkg::K_DEDENT; e_off = tok_begin;
            st.busy = 1'b1;
          end else if (top != align_pos) begin
            e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = tok_begin;
            e_code = iyt_pkg::E_INDENT; err_next = 1'b1;
          end else if (cont_flush) begin
            e_v = 1'b1; e_off = tok_begin; e_len = OFFSET_BITS'(k);
          end else begin
            mode_next = cont_mode;
            st.again  = 1'b1;
          end
          if (!st.busy) pass_next = pass + 3'd1;
        end
        iyt_pkg::P_POPALL: begin
          if (cnt > CNT_W'(1)) begin
            cnt_next = cnt_m1;
            e_v = 1'b1; e_kind = iyt_pkg::K_DEDENT; e_off = tok_begin;
            st.busy = 1'b1;
          end else begin
            e_v = 1'b1; e_kind = iyt_pkg::K_END; e_off = tok_begin; e_len = OFFSET_BITS'(3);
            mode_next   = dots ? iyt_pkg::M_DONE : iyt_pkg::M_COMMENT;
            marker_next = 3'd0;
          end
        end
        iyt_pkg::P_FLUSH: begin
          if (!err_stop) begin
            case (mode)
              iyt_pkg::M_LINE_START: begin
                if (k != 2'd0) begin
                  st.go_align     = 1'b1;
                  align_pos_next  = '0;
                  cont_flush_next = 1'b1;
                  first_next      = 1'b1;
                end
              end
              iyt_pkg::M_DASH_PEND, iyt_pkg::M_BARE_LINE: begin
                e_v = 1'b1; e_off = tok_begin;
                e_len = offset + OFFSET_BITS'(1) - tok_begin;
              end
              iyt_pkg::M_BARE_LIST: begin
                e_v = 1'b1; e_off = tok_begin;
                e_len = offset + OFFSET_BITS'(1) - tok_begin;
                st.go_flush2 = 1'b1;
              end
              iyt_pkg::M_QUOTE_LINE, iyt_pkg::M_QUOTE_LIST: begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = tok_begin;
                e_code = iyt_pkg::E_STRING; err_next = 1'b1;
              end
              iyt_pkg::M_LIST: begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = list_begin;
                e_code = iyt_pkg::E_UNCLOSED; err_next = 1'b1;
              end
              iyt_pkg::M_AFTER_CLOSE: begin
                e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = tok_begin;
                e_code = iyt_pkg::E_NO_NEWLINE; err_next = 1'b1;
              end
              default: begin
                e_v = 1'b0;
              end
            endcase
          end
        end
        iyt_pkg::P_FLUSH2: begin
          e_v = 1'b1; e_kind = iyt_pkg::K_ERROR; e_off = list_begin;
          e_code = iyt_pkg::E_UNCLOSED; err_next = 1'b1;
        end
        iyt_pkg::P_FINISH: begin
          if (eot) begin
            mode_next   = iyt_pkg::M_LINE_START;
            cnt_next    = CNT_W'(1);
            column_next = '0;
            offset_next = '0;
            tok_next    = '0;
            list_next   = '0;
            marker_next = 3'd0;
            err_next    = 1'b0;
          end else begin
            offset_next = offset + OFFSET_BITS'(1);
            if (nl_taken) column_next = '0;
            else if (column != {COLUMN_BITS{1'b1}}) column_next = column + COLUMN_BITS'(1);
          end
        end
        default: begin
          e_v = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= iyt_pkg::M_LINE_START;
      cnt         <= CNT_W'(1);
      column      <= '0;
      offset      <= '0;
      tok_begin   <= '0;
      list_begin  <= '0;
      marker      <= 3'd0;
      err_stop    <= 1'b0;
      nl_taken    <= 1'b0;
      pass        <= 3'd0;
      align_first <= 1'b0;
      cont_flush  <= 1'b0;
      cont_mode   <= iyt_pkg::M_LINE;
      res_cnt     <= '0;
      held_v      <= 1'b0;
      m_tvalid    <= 1'b0;
      stack[0]    <= '0;
    end else begin
      mode        <= mode_next;
      cnt         <= cnt_next;
      column      <= column_next;
      offset      <= offset_next;
      tok_begin   <= tok_next;
      list_begin  <= list_next;
      marker      <= marker_next;
      err_stop    <= err_next;
      nl_taken    <= nl_next;
      pass        <= pass_next;
      align_first <= first_next;
      cont_flush  <= cont_flush_next;
      cont_mode   <= cont_mode_next;
      if (cmd.accept) res_cnt <= '0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (e_take) begin
        res_cnt <= res_cnt + iyt_pkg::RES_W'(1);
        held_v  <= 1'b1;
        if (held_v) m_tvalid <= 1'b1;
      end
      if (finish_run && held_v) begin
        held_v   <= 1'b0;
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    align_pos <= align_pos_next;
    if (cmd.accept) begin
      cbyte <= s_tdata;
      eot   <= s_tlast;
    end
    if (push_v) stack[cnt[IDX_W-1:0]] <= cnt_next == CNT_W'(1) ? '0 :
                                         (cmd.op == iyt_pkg::P_ALIGN ? align_pos : column);
    if (e_take) begin
      h_kind <= e_kind;
      h_off  <= e_off;
      h_len  <= e_len;
      h_code <= e_code;
      if (held_v) begin
        o_kind <= h_kind;
        o_off  <= h_off;
        o_len  <= h_len;
        o_code <= h_code;
        o_last <= 1'b0;
      end
    end
    if (finish_run && held_v) begin
      o_kind <= h_kind;
      o_off  <= h_off;
      o_len  <= h_len;
      o_code <= h_code;
      o_last <= 1'b1;
    end
  end

  assign m_tuser = o_kind;
  assign m_tlast = o_last;
  assign m_tdata = {5'b0, o_code, iyt_pkg::OUT_W'(o_len), iyt_pkg::OUT_W'(o_off)};

endmodule

// ===== rtl/indent_yaml_tokenizer.sv =====
// A byte runs through scan passes, stack pops or pushes for indents and
// dedents, and end of text handling. Throughput: one byte at a time; the
// dedent run walks the column stack one entry per cycle unless the output
// stalls, and each token leaves through a single output register.
// Reset (rst, synchronous) returns the scanner to line start with an empty
// stack; it also returns there by itself after the last byte of a text.
// ----------------------------------------------------------------------------
// indent_yaml_tokenizer
// Byte stream tokenizer for a YAML subset with indent and dedent tokens.
// ----------------------------------------------------------------------------
module indent_yaml_tokenizer #(
  parameter int STACK_DEPTH = iyt_pkg::STACK_DEPTH_DEF,
  parameter int COLUMN_BITS = iyt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = iyt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // token_offset, token_length, error_code
  output logic [3:0]  m_tuser,   // token_kind
  output logic        m_tlast    // run_last
);

  iyt_pkg::cmd_t    cmd;
  iyt_pkg::status_t st;

  iyt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  iyt_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
